>>> hdl/flow_byte_accounting_table_macros.svh
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef FLOW_BYTE_ACCOUNTING_TABLE_MACROS_SVH
`define FLOW_BYTE_ACCOUNTING_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBAT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flow table check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define FBAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flow table check failed in the next cycle");

`endif

>>> hdl/fbat_pkg.sv
package fbat_pkg;

  // Table geometry.
  localparam int FLOW_SLOTS = 32;
  localparam int SLOT_IW    = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CNT_W      = $clog2(FLOW_SLOTS + 1);

  // Field widths.
  localparam int PROTO_W = 8;
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int LEN_W   = 16;
  localparam int BYTES_W = 32;
  localparam int CAP_W   = 20;

  // Report threshold: floor(floor(bytes / 10) / 1000) equals floor(bytes / 10000),
  // so a flow is reported when bytes >= rate_cap * 10000.
  localparam int DIV_TENS      = 10;
  localparam int DIV_THOUSANDS = 1000;
  localparam int RATE_DIV      = DIV_TENS * DIV_THOUSANDS;
  localparam int DIV_W         = $clog2(RATE_DIV + 1);
  localparam int THR_W         = CAP_W + DIV_W;

  // Input transaction payload, first field in the lowest bits.
  typedef struct packed {
    logic [LEN_W-1:0]   pkt_len;
    logic [PORT_W-1:0]  dst_port;
    logic [ADDR_W-1:0]  dst_addr;
    logic [PORT_W-1:0]  src_port;
    logic [ADDR_W-1:0]  src_addr;
    logic [PROTO_W-1:0] proto;
  } in_data_t;

  localparam int IN_DATA_W = $bits(in_data_t);
  localparam int OUT_FIELD_W = PROTO_W + 2 * ADDR_W + 2 * PORT_W + BYTES_W + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

  // Result transaction payload, first field in the lowest bits.
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic                 overflow_seen;
    logic [BYTES_W-1:0]   out_bytes;
    logic [PORT_W-1:0]    out_dst_port;
    logic [ADDR_W-1:0]    out_dst_addr;
    logic [PORT_W-1:0]    out_src_port;
    logic [ADDR_W-1:0]    out_src_addr;
    logic [PROTO_W-1:0]   out_proto;
  } out_data_t;

  // One entry of the flow memory: destination and running byte count.
  typedef struct packed {
    logic [ADDR_W-1:0]  dst_addr;
    logic [PORT_W-1:0]  dst_port;
    logic [BYTES_W-1:0] bytes;
  } ram_entry_t;

  localparam int ENTRY_W = $bits(ram_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic match;
    logic resolve;
    logic upd;
    logic alloc;
    logic set_ovf;
    logic rpt_init;
    logic idx_dec;
    logic rd_rpt;
    logic load_flow;
    logic load_mark;
    logic clear;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cmd_rpt;
    logic any_hit;
    logic full;
    logic empty;
    logic pass;
    logic idx_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> hdl/fbat_ram.sv
module fbat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/fbat_datapath.sv
module fbat_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fbat_pkg::ctrl_cmd_t            cmd,
  output fbat_pkg::ctrl_sts_t            sts,
  input  logic                           in_tuser,
  input  logic [fbat_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           cfg_we,
  input  logic [fbat_pkg::CAP_W-1:0]     cfg_wdata,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [fbat_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  output logic                           out_tlast
);

  localparam int IW = fbat_pkg::SLOT_IW;
  localparam int CW = fbat_pkg::CNT_W;
  localparam int NS = fbat_pkg::FLOW_SLOTS;

  // Latched input transaction.
  fbat_pkg::in_data_t in_r;
  logic               cmd_r;

  // Flow keys in flip-flops so that every slot is compared at once.
  logic [fbat_pkg::PROTO_W-1:0] slot_proto_r    [NS];
  logic [fbat_pkg::ADDR_W-1:0]  slot_src_addr_r [NS];
  logic [fbat_pkg::PORT_W-1:0]  slot_src_port_r [NS];

  logic [CW-1:0]                 count_r;
  logic                          ovf_r;
  logic [fbat_pkg::THR_W-1:0]    thr_r;
  logic [IW-1:0]                 idx_r;
  logic [NS-1:0]                 hit_vec_r;
  logic [NS-1:0]                 hit_vec_nxt;
  logic [IW-1:0]                 hit_idx_r;
  logic [IW-1:0]                 hit_enc;

  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr;
  fbat_pkg::ram_entry_t          ram_wdata;
  logic [IW-1:0]                 ram_raddr;
  fbat_pkg::ram_entry_t          ram_rdata;

  logic [fbat_pkg::BYTES_W:0]    sum;
  logic [fbat_pkg::BYTES_W-1:0]  sat_bytes;
  logic [IW-1:0]                 alloc_idx;

  logic                          out_valid_r;
  fbat_pkg::out_data_t           out_data_r;
  logic                          out_flow_r;
  logic                          out_last_r;

  assign alloc_idx = count_r[IW-1:0];

  // Latch the accepted input transaction.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r  <= fbat_pkg::in_data_t'(in_tdata);
      cmd_r <= in_tuser;
    end
  end

  // Threshold register: the cap scaled by ten thousand.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= fbat_pkg::THR_W'(cfg_wdata) * fbat_pkg::THR_W'(fbat_pkg::RATE_DIV);
    end
  end

  // Key match against every filled slot.
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      hit_vec_nxt[i] = (CW'(i) < count_r) &&
                       (slot_proto_r[i] == in_r.proto) &&
                       (slot_src_addr_r[i] == in_r.src_addr) &&
                       (slot_src_port_r[i] == in_r.src_port);
    end
  end

  // Keys are unique, so at most one bit is set and an OR encoder suffices.
  always_comb begin
    hit_enc = '0;
    for (int i = 0; i < NS; i++) begin
      if (hit_vec_r[i]) begin
        hit_enc = hit_enc | IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_vec_r <= hit_vec_nxt;
    end
    if (cmd.resolve) begin
      hit_idx_r <= hit_enc;
    end
  end

  // New flows take the next free slot.
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      slot_proto_r[alloc_idx]    <= in_r.proto;
      slot_src_addr_r[alloc_idx] <= in_r.src_addr;
      slot_src_port_r[alloc_idx] <= in_r.src_port;
    end
  end

  // Saturating byte update for a hit.
  always_comb begin
    sum       = {1'b0, ram_rdata.bytes} + (fbat_pkg::BYTES_W + 1)'(in_r.pkt_len);
    sat_bytes = sum[fbat_pkg::BYTES_W] ? '1 : sum[fbat_pkg::BYTES_W-1:0];
  end

  // Flow memory write and read address selection.
  always_comb begin
    ram_we    = cmd.upd || cmd.alloc;
    ram_waddr = cmd.upd ? hit_idx_r : alloc_idx;
    if (cmd.upd) begin
      ram_wdata.dst_addr = ram_rdata.dst_addr;
      ram_wdata.dst_port = ram_rdata.dst_port;
      ram_wdata.bytes    = sat_bytes;
    end else begin
      ram_wdata.dst_addr = in_r.dst_addr;
      ram_wdata.dst_port = in_r.dst_port;
      ram_wdata.bytes    = fbat_pkg::BYTES_W'(in_r.pkt_len);
    end
    ram_raddr = cmd.rd_rpt ? idx_r : hit_enc;
  end

  fbat_ram #(
    .WIDTH (fbat_pkg::ENTRY_W),
    .DEPTH (fbat_pkg::FLOW_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Fill count, sticky overflow flag and report index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (cmd.alloc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.clear) begin
        count_r <= '0;
      end
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.rpt_init) begin
        idx_r <= IW'(count_r - CW'(1));
      end else if (cmd.idx_dec) begin
        idx_r <= idx_r - IW'(1);
      end
    end
  end

  // Output register: frees the input side while a result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_flow || cmd.load_mark) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_flow) begin
      out_data_r.pad           <= '0;
      out_data_r.overflow_seen <= ovf_r;
      out_data_r.out_bytes     <= ram_rdata.bytes;
      out_data_r.out_dst_port  <= ram_rdata.dst_port;
      out_data_r.out_dst_addr  <= ram_rdata.dst_addr;
      out_data_r.out_src_port  <= slot_src_port_r[idx_r];
      out_data_r.out_src_addr  <= slot_src_addr_r[idx_r];
      out_data_r.out_proto     <= slot_proto_r[idx_r];
      out_flow_r               <= 1'b1;
      out_last_r               <= 1'b0;
    end else if (cmd.load_mark) begin
      out_data_r.pad           <= '0;
      out_data_r.overflow_seen <= ovf_r;
      out_data_r.out_bytes     <= '0;
      out_data_r.out_dst_port  <= '0;
      out_data_r.out_dst_addr  <= '0;
      out_data_r.out_src_port  <= '0;
      out_data_r.out_src_addr  <= '0;
      out_data_r.out_proto     <= '0;
      out_flow_r               <= 1'b0;
      out_last_r               <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flow_r;
  assign out_tlast  = out_last_r;

  // Status toward the controller.
  always_comb begin
    sts.cmd_rpt  = cmd_r;
    sts.any_hit  = |hit_vec_r;
    sts.full     = (count_r == CW'(NS));
    sts.empty    = (count_r == '0);
    sts.pass     = (fbat_pkg::THR_W'(ram_rdata.bytes) >= thr_r);
    sts.idx_zero = (idx_r == '0);
    sts.out_free = !out_valid_r || out_tready;
  end

endmodule

>>> hdl/fbat_ctrl.sv
module fbat_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  fbat_pkg::ctrl_sts_t sts,
  output fbat_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DECODE  = 7'b0000010,
    ST_RESOLVE = 7'b0000100,
    ST_UPDATE  = 7'b0001000,
    ST_RPT_RD  = 7'b0010000,
    ST_RPT_CHK = 7'b0100000,
    ST_MARK    = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.cmd_rpt) begin
          if (sts.empty) begin
            state_nxt = ST_MARK;
          end else begin
            cmd.rpt_init = 1'b1;
            state_nxt    = ST_RPT_RD;
          end
        end else begin
          cmd.match = 1'b1;
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        if (sts.any_hit) begin
          state_nxt = ST_UPDATE;
        end else begin
          cmd.alloc   = !sts.full;
          cmd.set_ovf = sts.full;
          state_nxt   = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RPT_RD: begin
        cmd.rd_rpt = 1'b1;
        state_nxt  = ST_RPT_CHK;
      end
      ST_RPT_CHK: begin
        cmd.rd_rpt = 1'b1;
        // A passing flow waits here until the output register is free.
        if (!sts.pass || sts.out_free) begin
          cmd.load_flow = sts.pass;
          if (sts.idx_zero) begin
            state_nxt = ST_MARK;
          end else begin
            cmd.idx_dec = 1'b1;
            state_nxt   = ST_RPT_RD;
          end
        end
      end
      ST_MARK: begin
        if (sts.out_free) begin
          cmd.load_mark = 1'b1;
          cmd.clear     = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/flow_byte_accounting_table.sv
// Channel   Direction  Handshake           Payload
// in_*      input      tvalid/tready       tuser: cmd; tdata: packet fields
// out_*     output     tvalid/tready       tuser: flow_valid; tdata; tlast: last
// cfg_*     input      write enable only   wdata: rate_cap
//
// A packet transaction runs IDLE, DECODE and RESOLVE on a miss, plus UPDATE on
// a hit: match of all slot keys in parallel, then one read-modify-write of the
// flow memory. An interval runs DECODE, then RPT_RD and RPT_CHK per filled slot
// (registered flow memory read), then MARK; output stalls hold RPT_CHK and MARK.
// Reset is synchronous and active low; it empties the table and needs no sweep.
// A result waits in the output register while the next input is accepted.
module flow_byte_accounting_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata, low bit up: proto, src_addr, src_port, dst_addr, dst_port, pkt_len
  input  logic [fbat_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: cmd
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata, low bit up: out_proto, out_src_addr, out_src_port, out_dst_addr,
  // out_dst_port, out_bytes, overflow_seen, zero fill
  output logic [fbat_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: flow_valid
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [fbat_pkg::CAP_W-1:0]      cfg_wdata
);

  fbat_pkg::ctrl_cmd_t cmd;
  fbat_pkg::ctrl_sts_t sts;

  fbat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbat_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> hdl/fbat_checker.sv
`include "flow_byte_accounting_table_macros.svh"

module fbat_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fbat_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  localparam int OVF_BIT = fbat_pkg::OUT_FIELD_W - 1;

  // A stalled result transaction keeps its payload.
  `FBAT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // A flow report is never the closing marker.
  `FBAT_ASSERT_NOW(a_flow_not_last, out_tvalid && out_tuser, !out_tlast)

  // The marker carries only the overflow flag.
  `FBAT_ASSERT_NOW(a_mark_zero, out_tvalid && out_tlast, !out_tuser && (out_tdata[OVF_BIT-1:0] == '0))

  // Once reported, the overflow flag stays set on every later result.
  `FBAT_ASSERT_NEXT(a_ovf_sticky, out_tvalid && out_tdata[OVF_BIT], !out_tvalid || out_tdata[OVF_BIT])

endmodule

bind flow_byte_accounting_table fbat_checker u_fbat_checker (.*);
